/* hw/rtl/selective_repeat_send_window_core_assert.svh */
// Assertion macros for the send window core.
// Included by the modules that assert; no other dependencies.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SRSW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/srsw_pkg.sv */
// Shared types and constants for the send window core.
// No dependencies.
package srsw_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_MARK    = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_DROP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;    // take neighbor's entry
        logic load;     // store appended number, clear mark
        logic ack_set;  // set mark on the entry being taken in
    } t_cell_ctl;

    localparam logic [5:0] LIMIT_RST = 6'd32;

endpackage

/* hw/rtl/srsw_cell.sv */
// One window cell: a sequence number and its acknowledged mark.
// Depends on srsw_pkg.
module srsw_cell #(
    parameter int SEQ_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srsw_pkg::t_cell_ctl   i_ctl,
    input  logic [SEQ_BITS-1:0]   i_nxt_seq,
    input  logic                  i_nxt_ack,
    input  logic [SEQ_BITS-1:0]   i_load_seq,
    output logic [SEQ_BITS-1:0]   o_seq,
    output logic                  o_ack
);
    import srsw_pkg::*;

    logic [SEQ_BITS-1:0] r_seq;
    logic                r_ack;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_seq <= i_load_seq;
        end else if (i_ctl.shift) begin
            r_seq <= i_nxt_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack <= 1'b0;
        end else if (i_ctl.load) begin
            r_ack <= 1'b0;
        end else if (i_ctl.shift) begin
            r_ack <= i_nxt_ack | i_ctl.ack_set;
        end
    end

    assign o_seq = r_seq;
    assign o_ack = r_ack;

endmodule

/* hw/rtl/selective_repeat_send_window_core.sv */
// Append loads the tail cell, then the result register; a mark turns
// the ring DEPTH places; advance and drop rotate once per entry popped.
// One item at a time: the ring of cells rotates one place per cycle.
// Next item accepted once the result is in the output register.
// Reset (sync, active low): window empty, marks cleared, limit 32.
module selective_repeat_send_window_core #(
    parameter int DEPTH    = 32,
    parameter int SEQ_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_seq_num,
    input  logic [5:0]  i_drop_count,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted,
    output logic        o_match_found,
    output logic [5:0]  o_removed,
    output logic [5:0]  o_occupancy,
    output logic [31:0] o_front_seq,
    output logic        o_room_left,
    // window_limit register
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata
);
    import srsw_pkg::*;
    `include "selective_repeat_send_window_core_assert.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > 6) ? CNT_W : 6;

    // ------------------------------------------------------------------
    // Cell ring. Cell 0 holds the front entry except during a mark's turn.
    // A rotation moves every entry one place toward the front; cell 0
    // wraps to the last cell, so a full turn of DEPTH steps restores the
    // order. A pop is a single rotation with the count decremented: the
    // popped entry lands beyond the occupied part and is never read again.
    // ------------------------------------------------------------------
    t_cell_ctl            ctl   [DEPTH];
    logic [SEQ_BITS-1:0]  c_seq [DEPTH];
    logic                 c_ack [DEPTH];

    // control and request registers
    t_state               r_state, n_state;
    t_req                 r_req,   n_req;
    logic [SEQ_BITS-1:0]  r_seq,   n_seq;
    logic [5:0]           r_left,  n_left;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_rem,   n_rem;
    logic [IDX_W-1:0]     r_step,  n_step;
    logic                 r_found, n_found;
    logic                 r_acc,   n_acc;
    logic [5:0]           r_limit;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_o_acc, r_o_match, r_o_room;
    logic [5:0]           r_o_rem, r_o_occ;
    logic [31:0]          r_o_front;
    logic                 out_load;

    logic                 room;
    logic                 do_shift;
    logic                 do_load;
    logic                 hit;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int NXT = (g + 1) % DEPTH;

        assign ctl[g].shift   = do_shift;
        assign ctl[g].load    = do_load && (r_count == CNT_W'(g));
        assign ctl[g].ack_set = (g == DEPTH - 1) ? hit : 1'b0;

        srsw_cell #(
            .SEQ_BITS (SEQ_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl[g]),
            .i_nxt_seq  (c_seq[NXT]),
            .i_nxt_ack  (c_ack[NXT]),
            .i_load_seq (r_seq),
            .o_seq      (c_seq[g]),
            .o_ack      (c_ack[g])
        );
    end

    // effective limit is window_limit capped at DEPTH
    assign room = (LIM_W'(r_count) < LIM_W'(r_limit)) &&
                  (LIM_W'(r_count) < LIM_W'(DEPTH));

    // mark: cell 0 holds entry r_step while the ring turns
    assign hit = (r_state == ST_RUN) && (r_req == REQ_MARK) && !r_found &&
                 (CNT_W'(r_step) < r_count) && (c_seq[0] == r_seq);

    assign o_in_ready = (r_state == ST_IDLE);
    assign out_load   = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_seq       = r_seq;
        n_left      = r_left;
        n_count     = r_count;
        n_rem       = r_rem;
        n_step      = r_step;
        n_found     = r_found;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        do_shift    = 1'b0;
        do_load     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = t_req'(i_req_type);
                    n_seq   = SEQ_BITS'(i_seq_num);
                    n_left  = i_drop_count;
                    n_rem   = '0;
                    n_step  = '0;
                    n_found = 1'b0;
                    n_acc   = 1'b0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                unique case (r_req)
                    REQ_APPEND: begin
                        if (room) begin
                            do_load = 1'b1;
                            n_count = r_count + 1'b1;
                            n_acc   = 1'b1;
                        end
                        n_state = ST_FIN;
                    end
                    REQ_MARK: begin
                        do_shift = 1'b1;
                        n_step   = r_step + 1'b1;
                        if (hit) begin
                            n_found = 1'b1;
                        end
                        if (r_step == IDX_W'(DEPTH - 1)) begin
                            n_state = ST_FIN;
                        end
                    end
                    REQ_ADVANCE: begin
                        if ((r_count != '0) && c_ack[0]) begin
                            do_shift = 1'b1;
                            n_count  = r_count - 1'b1;
                            n_rem    = r_rem + 1'b1;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                    REQ_DROP: begin
                        if ((r_count != '0) && (r_left != '0)) begin
                            do_shift = 1'b1;
                            n_count  = r_count - 1'b1;
                            n_rem    = r_rem + 1'b1;
                            n_left   = r_left - 1'b1;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_FIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // request payload and working counters
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_seq   <= n_seq;
        r_left  <= n_left;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_found <= n_found;
        r_acc   <= n_acc;
    end

    // result fields taken after the update has settled into the ring
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_acc   <= r_acc;
            r_o_match <= r_found;
            r_o_rem   <= 6'(r_rem);
            r_o_occ   <= 6'(r_count);
            r_o_front <= (r_count != '0) ? 32'(c_seq[0]) : 32'd0;
            r_o_room  <= room;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_o_acc;
    assign o_match_found = r_o_match;
    assign o_removed     = r_o_rem;
    assign o_occupancy   = r_o_occ;
    assign o_front_seq   = r_o_front;
    assign o_room_left   = r_o_room;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SRSW_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        LIM_W'(r_count) <= LIM_W'(DEPTH), "occupancy above depth")
    `SRSW_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n,
        do_shift && (r_req != REQ_MARK), r_count != '0, "pop from empty window")
    `SRSW_ASSERT_NOW(a_load_room, i_clk, i_rst_n, do_load, room && !do_shift,
        "append without room or during rotation")
    `SRSW_ASSERT_NXT(a_mark_count, i_clk, i_rst_n,
        (r_state == ST_RUN) && (r_req == REQ_MARK), r_count == $past(r_count),
        "mark changed occupancy")

endmodule
